[rtl/core/fpad_pkg.sv]
// Shared types, codes and defaults of the flight phase apogee detector.
`default_nettype none

package fpad_pkg;

    localparam int ALT_WIDTH_DEF  = 24;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int SAMPLES_W      = 8;
    localparam int HOLD_W         = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int PHASE_W        = 3;

    localparam int LIFTOFF_RESET     = 320;
    localparam int SAMPLES_RESET     = 5;
    localparam int APOGEE_TO_RESET   = 30000;
    localparam int RECORD_TO_RESET   = 300000;
    localparam int RECORD_TO_MIN_W   = 19;
    localparam int ABORT_HOLD_RESET  = 10;
    localparam int LANDED_HOLD_RESET = 10;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_LIFTOFF     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUND_REF  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_APOGEE_TO   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_TO   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ABORT_HOLD  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LANDED_HOLD = 3'd6;

    // Phase codes as reported on the result channel
    localparam logic [PHASE_W-1:0] PHASE_CODE_GROUND  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_ASCENT  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DESCENT = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_LANDED  = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_CODE_ABORTED = 3'd4;

    typedef enum logic [4:0] {
        PH_GROUND  = 5'b00001,
        PH_ASCENT  = 5'b00010,
        PH_DESCENT = 5'b00100,
        PH_LANDED  = 5'b01000,
        PH_ABORTED = 5'b10000
    } phase_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_GROUND:  code = PHASE_CODE_GROUND;
            PH_ASCENT:  code = PHASE_CODE_ASCENT;
            PH_DESCENT: code = PHASE_CODE_DESCENT;
            PH_LANDED:  code = PHASE_CODE_LANDED;
            PH_ABORTED: code = PHASE_CODE_ABORTED;
            default:    code = PHASE_CODE_GROUND;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fpad_sample_if.sv]
// Sample request channel: altitude and timestamp with valid/ready.
`default_nettype none

interface fpad_sample_if #(
    parameter int ALT_W  = fpad_pkg::ALT_WIDTH_DEF,
    parameter int TIME_W = fpad_pkg::TIME_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic signed [ALT_W-1:0]  altitude;
    logic        [TIME_W-1:0] timestamp;

    modport source (output valid, altitude, timestamp, input ready);
    modport sink   (input valid, altitude, timestamp, output ready);
endinterface

`default_nettype wire

[rtl/core/fpad_result_if.sv]
// Result channel: phase, altitude change and apogee/touchdown records.
`default_nettype none

interface fpad_result_if #(
    parameter int ALT_W  = fpad_pkg::ALT_WIDTH_DEF,
    parameter int TIME_W = fpad_pkg::TIME_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic        [fpad_pkg::PHASE_W-1:0] phase;
    logic                                phase_changed;
    logic signed [ALT_W:0]               altitude_change;
    logic signed [ALT_W-1:0]             apogee_altitude;
    logic        [TIME_W-1:0]            apogee_time;
    logic signed [ALT_W-1:0]             touchdown_altitude;
    logic        [TIME_W-1:0]            touchdown_time;

    modport source (output valid, phase, phase_changed, altitude_change, apogee_altitude,
                    apogee_time, touchdown_altitude, touchdown_time, input ready);
    modport sink   (input valid, phase, phase_changed, altitude_change, apogee_altitude,
                    apogee_time, touchdown_altitude, touchdown_time, output ready);
endinterface

`default_nettype wire

[rtl/core/fpad_cfg.sv]
// Configuration register file with plain write port.
`default_nettype none

module fpad_cfg #(
    parameter int ALT_WIDTH  = fpad_pkg::ALT_WIDTH_DEF,
    parameter int TIME_WIDTH = fpad_pkg::TIME_WIDTH_DEF,
    parameter int CFG_W      = (ALT_WIDTH > TIME_WIDTH) ? ALT_WIDTH : TIME_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [fpad_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]                     cfg_data,
    output logic      [ALT_WIDTH-2:0]                 liftoff_reg,
    output logic signed [ALT_WIDTH-1:0]               ground_ref_reg,
    output logic      [fpad_pkg::SAMPLES_W-1:0]       samples_reg,
    output logic      [TIME_WIDTH-1:0]                apogee_to_reg,
    output logic      [TIME_WIDTH-1:0]                record_to_reg,
    output logic      [fpad_pkg::HOLD_W-1:0]          abort_hold_reg,
    output logic      [fpad_pkg::HOLD_W-1:0]          landed_hold_reg
);
    import fpad_pkg::*;

    // Saturate the recording timeout default when the timer is too narrow for it
    localparam logic [TIME_WIDTH-1:0] RECORD_TO_INIT = (TIME_WIDTH >= RECORD_TO_MIN_W) ?
        TIME_WIDTH'(RECORD_TO_RESET) : {TIME_WIDTH{1'b1}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            liftoff_reg     <= (ALT_WIDTH-1)'(LIFTOFF_RESET);
            ground_ref_reg  <= '0;
            samples_reg     <= SAMPLES_W'(SAMPLES_RESET);
            apogee_to_reg   <= TIME_WIDTH'(APOGEE_TO_RESET);
            record_to_reg   <= RECORD_TO_INIT;
            abort_hold_reg  <= HOLD_W'(ABORT_HOLD_RESET);
            landed_hold_reg <= HOLD_W'(LANDED_HOLD_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIFTOFF:     liftoff_reg     <= cfg_data[ALT_WIDTH-2:0];
                CFG_GROUND_REF:  ground_ref_reg  <= $signed(cfg_data[ALT_WIDTH-1:0]);
                CFG_SAMPLES:     samples_reg     <= cfg_data[SAMPLES_W-1:0];
                CFG_APOGEE_TO:   apogee_to_reg   <= cfg_data[TIME_WIDTH-1:0];
                CFG_RECORD_TO:   record_to_reg   <= cfg_data[TIME_WIDTH-1:0];
                CFG_ABORT_HOLD:  abort_hold_reg  <= cfg_data[HOLD_W-1:0];
                CFG_LANDED_HOLD: landed_hold_reg <= cfg_data[HOLD_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/fpad_core.sv]
// Flight phase state machine with apogee and touchdown records.
`default_nettype none

module fpad_core #(
    parameter int ALT_WIDTH  = fpad_pkg::ALT_WIDTH_DEF,
    parameter int TIME_WIDTH = fpad_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire logic signed [ALT_WIDTH-1:0]       alt,
    input  wire logic        [TIME_WIDTH-1:0]      ts,
    input  wire logic        [ALT_WIDTH-2:0]       liftoff,
    input  wire logic signed [ALT_WIDTH-1:0]       ground_ref,
    input  wire logic        [fpad_pkg::SAMPLES_W-1:0] samples,
    input  wire logic        [TIME_WIDTH-1:0]      apogee_to,
    input  wire logic        [TIME_WIDTH-1:0]      record_to,
    input  wire logic        [fpad_pkg::HOLD_W-1:0] abort_hold,
    input  wire logic        [fpad_pkg::HOLD_W-1:0] landed_hold,
    output logic             [fpad_pkg::PHASE_W-1:0] res_phase,
    output logic                                   res_changed,
    output logic signed      [ALT_WIDTH:0]         res_change,
    output logic signed      [ALT_WIDTH-1:0]       res_peak_alt,
    output logic             [TIME_WIDTH-1:0]      res_peak_time,
    output logic signed      [ALT_WIDTH-1:0]       res_land_alt,
    output logic             [TIME_WIDTH-1:0]      res_land_time
);
    import fpad_pkg::*;

    phase_t                     phase_reg, phase_next;
    logic [SAMPLES_W-1:0]       fall_cnt_reg, fall_cnt_next;
    logic signed [ALT_WIDTH-1:0] last_alt_reg, last_alt_next;
    logic [TIME_WIDTH-1:0]      launch_time_reg, launch_time_next;
    logic signed [ALT_WIDTH-1:0] ff_alt_reg, ff_alt_next;
    logic [TIME_WIDTH-1:0]      ff_time_reg, ff_time_next;
    logic signed [ALT_WIDTH-1:0] peak_alt_reg, peak_alt_next;
    logic [TIME_WIDTH-1:0]      peak_time_reg, peak_time_next;
    logic signed [ALT_WIDTH-1:0] land_alt_reg, land_alt_next;
    logic [TIME_WIDTH-1:0]      land_time_reg, land_time_next;
    logic [HOLD_W-1:0]          abort_ticks_reg, abort_ticks_next;
    logic [HOLD_W-1:0]          landed_ticks_reg, landed_ticks_next;

    logic [TIME_WIDTH-1:0]      t_since;
    logic [SAMPLES_W-1:0]       n_eff;
    logic signed [ALT_WIDTH:0]  diff_ref;
    logic signed [ALT_WIDTH:0]  diff_last;
    logic                       liftoff_hit;
    logic                       touch_hit;
    logic                       falling;
    logic                       apex;
    logic signed [ALT_WIDTH-1:0] ff_alt_rec;
    logic [TIME_WIDTH-1:0]      ff_time_rec;

    assign t_since   = ts - launch_time_reg;
    assign n_eff     = (samples == '0) ? SAMPLES_W'(1) : samples;
    assign diff_ref  = $signed({alt[ALT_WIDTH-1], alt}) -
                       $signed({ground_ref[ALT_WIDTH-1], ground_ref});
    assign diff_last = $signed({alt[ALT_WIDTH-1], alt}) -
                       $signed({last_alt_reg[ALT_WIDTH-1], last_alt_reg});
    assign liftoff_hit = diff_ref > $signed({2'b00, liftoff});
    assign touch_hit   = alt < $signed({2'b00, liftoff[ALT_WIDTH-2:1]});
    assign falling     = diff_last[ALT_WIDTH];
    // Last falling sample of the countdown confirms apogee
    assign apex        = falling && (fall_cnt_reg == SAMPLES_W'(1));
    // Record the first fall only while the countdown is still full
    assign ff_alt_rec  = (fall_cnt_reg == n_eff) ? alt : ff_alt_reg;
    assign ff_time_rec = (fall_cnt_reg == n_eff) ? t_since : ff_time_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        fall_cnt_next     = fall_cnt_reg;
        last_alt_next     = last_alt_reg;
        launch_time_next  = launch_time_reg;
        ff_alt_next       = ff_alt_reg;
        ff_time_next      = ff_time_reg;
        peak_alt_next     = peak_alt_reg;
        peak_time_next    = peak_time_reg;
        land_alt_next     = land_alt_reg;
        land_time_next    = land_time_reg;
        abort_ticks_next  = abort_ticks_reg;
        landed_ticks_next = landed_ticks_reg;
        res_change        = diff_ref;

        unique case (phase_reg)
            PH_GROUND:
            begin
                if (liftoff_hit)
                begin
                    launch_time_next = ts;
                    last_alt_next    = alt;
                    fall_cnt_next    = n_eff;
                    ff_alt_next      = '0;
                    ff_time_next     = '0;
                    peak_alt_next    = '0;
                    peak_time_next   = '0;
                    land_alt_next    = '0;
                    land_time_next   = '0;
                    phase_next       = PH_ASCENT;
                end
            end
            PH_ASCENT:
            begin
                res_change    = diff_last;
                last_alt_next = alt;
                if (falling)
                begin
                    ff_alt_next   = ff_alt_rec;
                    ff_time_next  = ff_time_rec;
                    fall_cnt_next = fall_cnt_reg - SAMPLES_W'(1);
                    if (apex)
                    begin
                        peak_alt_next  = ff_alt_rec;
                        peak_time_next = ff_time_rec;
                        phase_next     = PH_DESCENT;
                    end
                end
                else if (fall_cnt_reg < n_eff)
                begin
                    ff_alt_next   = '0;
                    ff_time_next  = '0;
                    fall_cnt_next = n_eff;
                end
                if (!apex && (t_since > apogee_to || t_since > record_to))
                begin
                    abort_ticks_next = '0;
                    phase_next       = PH_ABORTED;
                end
            end
            PH_DESCENT:
            begin
                res_change    = diff_last;
                last_alt_next = alt;
                if (t_since > record_to)
                begin
                    abort_ticks_next = '0;
                    phase_next       = PH_ABORTED;
                end
                else if (touch_hit)
                begin
                    land_alt_next  = alt;
                    land_time_next = t_since;
                    phase_next     = PH_LANDED;
                end
            end
            PH_LANDED:
            begin
                if (landed_ticks_reg > landed_hold || landed_ticks_reg == '1)
                begin
                    abort_ticks_next  = '0;
                    landed_ticks_next = '0;
                    phase_next        = PH_GROUND;
                end
                else
                begin
                    landed_ticks_next = landed_ticks_reg + HOLD_W'(1);
                end
            end
            PH_ABORTED:
            begin
                if (abort_ticks_reg > abort_hold || abort_ticks_reg == '1)
                    phase_next = PH_GROUND;
                else
                    abort_ticks_next = abort_ticks_reg + HOLD_W'(1);
            end
            default:
            begin
                phase_next = PH_GROUND;
            end
        endcase
    end

    assign res_phase     = phase_code(phase_next);
    assign res_changed   = (phase_next != phase_reg);
    assign res_peak_alt  = peak_alt_next;
    assign res_peak_time = peak_time_next;
    assign res_land_alt  = land_alt_next;
    assign res_land_time = land_time_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_GROUND;
            fall_cnt_reg     <= SAMPLES_W'(SAMPLES_RESET);
            last_alt_reg     <= '0;
            launch_time_reg  <= '0;
            ff_alt_reg       <= '0;
            ff_time_reg      <= '0;
            peak_alt_reg     <= '0;
            peak_time_reg    <= '0;
            land_alt_reg     <= '0;
            land_time_reg    <= '0;
            abort_ticks_reg  <= '0;
            landed_ticks_reg <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            fall_cnt_reg     <= fall_cnt_next;
            last_alt_reg     <= last_alt_next;
            launch_time_reg  <= launch_time_next;
            ff_alt_reg       <= ff_alt_next;
            ff_time_reg      <= ff_time_next;
            peak_alt_reg     <= peak_alt_next;
            peak_time_reg    <= peak_time_next;
            land_alt_reg     <= land_alt_next;
            land_time_reg    <= land_time_next;
            abort_ticks_reg  <= abort_ticks_next;
            landed_ticks_reg <= landed_ticks_next;
        end
    end

    // Ascent always has at least one falling sample left to confirm apogee
    a_ascent_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ASCENT |-> fall_cnt_reg != '0)
        else $error("fall countdown empty during ascent");

    // The landed counter only runs while landed
    a_landed_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_LANDED |-> landed_ticks_reg == '0)
        else $error("landed tick counter nonzero outside landed phase");

    // Liftoff stamps the launch time with the sample time
    a_launch_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_GROUND && liftoff_hit) |=>
        (phase_reg == PH_ASCENT && launch_time_reg == $past(ts)))
        else $error("liftoff did not stamp launch time");

endmodule

`default_nettype wire

[rtl/core/flight_phase_apogee_detector.sv]
// Flight phase and apogee detector: input stage, phase core and result stage.
// A request accepted into the input register passes through the phase logic into the
// result register, and only then can its result handshake come.
// Throughput: one request per cycle, set by the input register feeding the
// phase logic and the result register; a stalled result holds both stages.
// Reset: phase returns to ground, records and tick counters clear, the fall
// countdown and the configuration registers take their default values.
`default_nettype none

module flight_phase_apogee_detector #(
    parameter int ALT_WIDTH  = fpad_pkg::ALT_WIDTH_DEF,
    parameter int TIME_WIDTH = fpad_pkg::TIME_WIDTH_DEF,
    parameter int CFG_W      = (ALT_WIDTH > TIME_WIDTH) ? ALT_WIDTH : TIME_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    fpad_sample_if.sink                           sample,
    fpad_result_if.source                         result,
    input  wire logic                             cfg_we,
    input  wire logic [fpad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]                 cfg_data
);
    import fpad_pkg::*;

    logic                        s1_valid_reg;
    logic signed [ALT_WIDTH-1:0] s1_alt_reg;
    logic [TIME_WIDTH-1:0]       s1_ts_reg;
    logic                        out_valid_reg;
    logic [PHASE_W-1:0]          out_phase_reg;
    logic                        out_changed_reg;
    logic signed [ALT_WIDTH:0]   out_change_reg;
    logic signed [ALT_WIDTH-1:0] out_peak_alt_reg;
    logic [TIME_WIDTH-1:0]       out_peak_time_reg;
    logic signed [ALT_WIDTH-1:0] out_land_alt_reg;
    logic [TIME_WIDTH-1:0]       out_land_time_reg;

    logic                        advance;
    logic                        step;

    logic [ALT_WIDTH-2:0]        liftoff;
    logic signed [ALT_WIDTH-1:0] ground_ref;
    logic [SAMPLES_W-1:0]        samples;
    logic [TIME_WIDTH-1:0]       apogee_to;
    logic [TIME_WIDTH-1:0]       record_to;
    logic [HOLD_W-1:0]           abort_hold;
    logic [HOLD_W-1:0]           landed_hold;

    logic [PHASE_W-1:0]          res_phase;
    logic                        res_changed;
    logic signed [ALT_WIDTH:0]   res_change;
    logic signed [ALT_WIDTH-1:0] res_peak_alt;
    logic [TIME_WIDTH-1:0]       res_peak_time;
    logic signed [ALT_WIDTH-1:0] res_land_alt;
    logic [TIME_WIDTH-1:0]       res_land_time;

    // Advance whenever the result register is free or being drained
    assign advance      = !out_valid_reg || result.ready;
    assign step         = s1_valid_reg && advance;
    assign sample.ready = !s1_valid_reg || advance;

    fpad_cfg #(
        .ALT_WIDTH  (ALT_WIDTH),
        .TIME_WIDTH (TIME_WIDTH),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .liftoff_reg     (liftoff),
        .ground_ref_reg  (ground_ref),
        .samples_reg     (samples),
        .apogee_to_reg   (apogee_to),
        .record_to_reg   (record_to),
        .abort_hold_reg  (abort_hold),
        .landed_hold_reg (landed_hold)
    );

    fpad_core #(
        .ALT_WIDTH  (ALT_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .alt           (s1_alt_reg),
        .ts            (s1_ts_reg),
        .liftoff       (liftoff),
        .ground_ref    (ground_ref),
        .samples       (samples),
        .apogee_to     (apogee_to),
        .record_to     (record_to),
        .abort_hold    (abort_hold),
        .landed_hold   (landed_hold),
        .res_phase     (res_phase),
        .res_changed   (res_changed),
        .res_change    (res_change),
        .res_peak_alt  (res_peak_alt),
        .res_peak_time (res_peak_time),
        .res_land_alt  (res_land_alt),
        .res_land_time (res_land_time)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.valid && sample.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_alt_reg <= sample.altitude;
            s1_ts_reg  <= sample.timestamp;
        end
        if (step)
        begin
            out_phase_reg     <= res_phase;
            out_changed_reg   <= res_changed;
            out_change_reg    <= res_change;
            out_peak_alt_reg  <= res_peak_alt;
            out_peak_time_reg <= res_peak_time;
            out_land_alt_reg  <= res_land_alt;
            out_land_time_reg <= res_land_time;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.phase              = out_phase_reg;
    assign result.phase_changed      = out_changed_reg;
    assign result.altitude_change    = out_change_reg;
    assign result.apogee_altitude    = out_peak_alt_reg;
    assign result.apogee_time        = out_peak_time_reg;
    assign result.touchdown_altitude = out_land_alt_reg;
    assign result.touchdown_time     = out_land_time_reg;

    // An empty input stage always takes a request
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> sample.ready)
        else $error("input stage empty but request refused");

    // A stalled result keeps the pending request in the input stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |=> s1_valid_reg)
        else $error("pending request lost during result stall");

    // A request that reaches the core produces a result on the next edge
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed request produced no result");

endmodule

`default_nettype wire
